// ----- rtl/apjb_pkg.sv -----
`timescale 1ns / 1ps

package apjb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FILL_W     = 14;
    localparam int FLEN_W     = 13;
    localparam int THR_W      = 14;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [FLEN_W-1:0] FRAME_LEN_RESET = FLEN_W'(480);
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(9600);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] MODE_PREBUFFER = 2'd0;
    localparam logic [1:0] MODE_PLAY      = 2'd1;
    localparam logic [1:0] MODE_UNDERRUN  = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic              frame_end;
        logic [FILL_W-1:0] fill;
        logic [CNT_W-1:0]  underrun;
    } t_read_info;

endpackage

// ----- rtl/apjb_mem.sv -----
`timescale 1ns / 1ps

module apjb_mem #(
    parameter int DEPTH = 16384
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [apjb_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [apjb_pkg::SAMPLE_W-1:0] o_rd_data
);
    import apjb_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/apjb_ctrl.sv -----
`timescale 1ns / 1ps

module apjb_ctrl #(
    parameter int DEPTH = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [apjb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apjb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_store,
    input  logic                            i_read,
    input  logic [apjb_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                            o_wr_en,
    output logic [$clog2(DEPTH)-1:0]        o_wr_addr,
    output logic [apjb_pkg::SAMPLE_W-1:0]   o_wr_data,
    output logic                            o_rd_en,
    output logic [$clog2(DEPTH)-1:0]        o_rd_addr,
    output apjb_pkg::t_read_info            o_info
);
    import apjb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (PW > FILL_W) ? PW : FILL_W;

    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic              r_primed, n_primed;
    logic [FLEN_W-1:0] r_frame_rem, n_frame_rem;
    logic [1:0]        r_mode, n_mode;
    logic [CNT_W-1:0]  r_underrun, n_underrun;
    logic [FLEN_W-1:0] r_frame_len;
    logic [THR_W-1:0]  r_threshold;

    logic [FLEN_W-1:0] len;
    logic [FLEN_W-1:0] rem_start;
    logic [CW-1:0]     fill_now;
    logic [CW-1:0]     fill_after;

    function automatic logic [PW-1:0] f_advance(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] f_fill(input logic [PW-1:0] wp, input logic [PW-1:0] rp);
        logic [PW:0] diff;
        diff = {1'b0, wp} - {1'b0, rp};
        if (diff[PW]) begin
            diff = diff + (PW+1)'(DEPTH);
        end
        return diff[PW-1:0];
    endfunction

    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_primed    = r_primed;
        n_frame_rem = r_frame_rem;
        n_mode      = r_mode;
        n_underrun  = r_underrun;

        len       = (r_frame_len == '0) ? FLEN_W'(1) : r_frame_len;
        fill_now  = CW'(f_fill(r_wp, r_rp));
        rem_start = r_frame_rem;

        if (i_store) begin
            n_wp = f_advance(r_wp);
        end

        if (i_read) begin
            // mode is fixed once at the start of each frame
            if (r_frame_rem == '0) begin
                rem_start = len;
                if (!r_primed && fill_now < CW'(r_threshold)) begin
                    n_mode = MODE_PREBUFFER;
                end else if (fill_now < CW'(len)) begin
                    n_mode   = MODE_UNDERRUN;
                    n_primed = 1'b0;
                    if (r_underrun != '1) begin
                        n_underrun = r_underrun + CNT_W'(1);
                    end
                end else begin
                    n_mode   = MODE_PLAY;
                    n_primed = 1'b1;
                end
            end
            n_frame_rem = rem_start - FLEN_W'(1);
            if (n_mode == MODE_PLAY) begin
                n_rp = f_advance(r_rp);
            end
        end

        fill_after = CW'(f_fill(r_wp, n_rp));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_primed    <= 1'b0;
            r_frame_rem <= '0;
            r_mode      <= MODE_PREBUFFER;
            r_underrun  <= '0;
            r_frame_len <= FRAME_LEN_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_primed    <= n_primed;
            r_frame_rem <= n_frame_rem;
            r_mode      <= n_mode;
            r_underrun  <= n_underrun;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_LEN: r_frame_len <= i_cfg_data[FLEN_W-1:0];
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_wr_en   = i_store;
    assign o_wr_addr = r_wp;
    assign o_wr_data = i_sample;
    assign o_rd_en   = i_read && (n_mode == MODE_PLAY);
    assign o_rd_addr = r_rp;

    assign o_info.mode      = n_mode;
    assign o_info.frame_end = (n_frame_rem == '0);
    assign o_info.fill      = fill_after[FILL_W-1:0];
    assign o_info.underrun  = n_underrun;

endmodule

// ----- rtl/audio_playout_jitter_buffer.sv -----
`timescale 1ns / 1ps

// Playout jitter buffer for 16-bit audio on a DEPTH-entry ring of one synchronous
// RAM. A store request writes its sample and produces no result. For a read
// request the frame decision and the RAM read address are formed in the accept
// cycle; the RAM registers the read data and the output register then captures
// it. A new request is not accepted while a read is in flight or while a result
// is held in the output register under output stall. The sample RAM is not
// cleared: there is no startup sweep, and playing an entry that was never
// stored returns an unspecified sample. Frame length and prebuffer threshold
// are to be written through the config port only while the block is idle (the
// block does not enforce this) and take effect at the next frame start.
module audio_playout_jitter_buffer #(
    parameter int DEPTH = 16384
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_command,
    input  logic signed [apjb_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [apjb_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic [1:0]                           o_status,
    output logic                                 o_frame_end,
    output logic [apjb_pkg::FILL_W-1:0]          o_fill_level,
    output logic [apjb_pkg::CNT_W-1:0]           o_underrun_total,
    input  logic                                 i_cfg_we,
    input  logic [apjb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [apjb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import apjb_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic                r_pend;
    t_read_info          r_pend_info;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    t_read_info          r_out_info;

    logic                accept;
    logic                store;
    logic                read;
    logic                out_take;
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [PW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    t_read_info          info;

    // a read may start only if the output register is free by the time data returns
    assign o_in_stall = r_pend || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign store      = accept && (i_command == CMD_STORE);
    assign read       = accept && (i_command == CMD_READ);
    assign out_take   = r_out_valid && !i_out_stall;

    apjb_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_store     (store),
        .i_read      (read),
        .i_sample    (i_sample_in),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_info      (info)
    );

    apjb_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= read;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (read) begin
            r_pend_info <= info;
        end
        if (r_pend) begin
            r_out_info   <= r_pend_info;
            r_out_sample <= (r_pend_info.mode == MODE_PLAY) ? rd_data : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_out     = r_out_sample;
    assign o_status         = r_out_info.mode;
    assign o_frame_end      = r_out_info.frame_end;
    assign o_fill_level     = r_out_info.fill;
    assign o_underrun_total = r_out_info.underrun;

endmodule

// ----- dv/audio_playout_jitter_buffer_test.sv -----
`timescale 1ns / 1ps

module audio_playout_jitter_buffer_test;
    import apjb_pkg::*;

    localparam int RING_DEPTH        = 1 << FILL_W;
    localparam int SETTLE_CYCLES     = 8;
    localparam int CYCLE_LIMIT       = 2_000_000;
    localparam int RANDOM_PHASES     = 8;
    localparam int PHASE_ITEMS       = 100;
    localparam int PRESSURE_HOLD     = 60;
    localparam int LONG_FRAME        = 20;
    localparam int RESTART_THRESHOLD = 12;
    localparam int RESTART_FRAME     = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [1:0]          mode;
        logic                frame_end;
        logic [FILL_W-1:0]   fill;
        logic [CNT_W-1:0]    underrun;
    } t_playout;

    class playout_tracker;
        logic [SAMPLE_W-1:0] ring [RING_DEPTH];
        logic [FILL_W-1:0]   wr_ptr;
        logic [FILL_W-1:0]   rd_ptr;
        bit                  primed;
        logic [FLEN_W-1:0]   frame_left;
        logic [1:0]          mode;
        logic [CNT_W-1:0]    underruns;
        logic [FLEN_W-1:0]   frame_len;
        logic [THR_W-1:0]    threshold;
        t_playout            expected[$];
        int                  mismatches;

        function new();
            wr_ptr     = '0;
            rd_ptr     = '0;
            primed     = 1'b0;
            frame_left = '0;
            mode       = MODE_PREBUFFER;
            underruns  = '0;
            frame_len  = FRAME_LEN_RESET;
            threshold  = THRESHOLD_RESET;
            mismatches = 0;
        endfunction

        function logic [FILL_W-1:0] stored();
            return wr_ptr - rd_ptr;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FRAME_LEN) begin
                frame_len = data[FLEN_W-1:0];
            end else begin
                threshold = data[THR_W-1:0];
            end
        endfunction

        function void take_request(logic cmd, logic [SAMPLE_W-1:0] smp);
            logic [FILL_W-1:0] fill;
            logic [FLEN_W-1:0] len;
            t_playout          r;
            if (cmd == CMD_STORE) begin
                ring[wr_ptr] = smp;
                wr_ptr = wr_ptr + 1'b1;
                return;
            end
            // mode is latched once per frame
            if (frame_left == '0) begin
                fill = stored();
                len  = (frame_len == '0) ? FLEN_W'(1) : frame_len;
                if (!primed && fill < threshold) begin
                    mode = MODE_PREBUFFER;
                end else if (fill < len) begin
                    mode   = MODE_UNDERRUN;
                    primed = 1'b0;
                    if (underruns != '1) underruns = underruns + 1'b1;
                end else begin
                    mode   = MODE_PLAY;
                    primed = 1'b1;
                end
                frame_left = len;
            end
            r.sample = '0;
            if (mode == MODE_PLAY) begin
                r.sample = ring[rd_ptr];
                rd_ptr = rd_ptr + 1'b1;
            end
            frame_left  = frame_left - 1'b1;
            r.mode      = mode;
            r.frame_end = (frame_left == '0);
            r.fill      = stored();
            r.underrun  = underruns;
            expected.insert(expected.size(), r);
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t ns: %s expected %h got %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] smp, logic [1:0] status, logic fend,
                                   logic [FILL_W-1:0] fill, logic [CNT_W-1:0] cnt);
            t_playout r;
            if (expected.size() == 0) begin
                $display("%0t ns: unexpected result, expected none got sample %h status %h",
                         $time, smp, status);
                mismatches++;
                return;
            end
            r = expected.pop_front();
            check_field("sample_out", r.sample, smp);
            check_field("status", 16'(r.mode), 16'(status));
            check_field("frame_end", 16'(r.frame_end), 16'(fend));
            check_field("fill_level", 16'(r.fill), 16'(fill));
            check_field("underrun_total", r.underrun, cnt);
        endfunction
    endclass

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic                  i_command        = CMD_STORE;
    logic [SAMPLE_W-1:0]   i_sample_in      = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [SAMPLE_W-1:0]   o_sample_out;
    logic [1:0]            o_status;
    logic                  o_frame_end;
    logic [FILL_W-1:0]     o_fill_level;
    logic [CNT_W-1:0]      o_underrun_total;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = CFG_FRAME_LEN;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    playout_tracker tracker     = new();
    bit             idle_on     = 1'b1;
    int             stall_left  = 0;
    int             hold_cycles = 0;
    int             cycle_count = 0;

    audio_playout_jitter_buffer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_sample_in      (i_sample_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sample_out     (o_sample_out),
        .o_status         (o_status),
        .o_frame_end      (o_frame_end),
        .o_fill_level     (o_fill_level),
        .o_underrun_total (o_underrun_total),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d results outstanding", $time,
                     tracker.expected.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_sample_out, o_status, o_frame_end, o_fill_level,
                                 o_underrun_total);
        end
        if (hold_cycles > 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
        end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 4);
        end
        i_out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send(input logic cmd, input logic [SAMPLE_W-1:0] smp);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_sample_in <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_request(cmd, smp);
    endtask

    // stop requesting and wait until every read has answered
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_frame(input logic [CFG_DATA_W-1:0] len_word,
                                 input logic [CFG_DATA_W-1:0] thr_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_LEN;
        i_cfg_data  <= len_word;
        @(posedge i_clk);
        tracker.set_reg(CFG_FRAME_LEN, len_word);
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data  <= thr_word;
        @(posedge i_clk);
        tracker.set_reg(CFG_THRESHOLD, thr_word);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int                n;
        int                phase;
        int                store_pct;
        logic [FLEN_W-1:0] len;
        logic [THR_W-1:0]  thr;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_frame(CFG_DATA_W'(3), CFG_DATA_W'(4));
        send(CMD_STORE, 16'h8000);
        send(CMD_STORE, 16'h7fff);
        send(CMD_STORE, 16'h0000);
        // below threshold, not primed: silent frame
        repeat (3) send(CMD_READ, 16'hffff);
        send(CMD_STORE, 16'hffff);
        repeat (3) send(CMD_READ, 16'h0000);
        // one sample left for a frame of three
        repeat (3) send(CMD_READ, 16'h1234);
        send(CMD_STORE, 16'h5555);
        send(CMD_STORE, 16'haaaa);
        send(CMD_STORE, 16'h0001);
        send(CMD_STORE, 16'hfffe);
        send(CMD_STORE, 16'h4000);
        send(CMD_READ, 16'h8000);
        settle();
        // new length only applies once the open frame runs out
        program_frame(CFG_DATA_W'(1), '0);
        repeat (3) send(CMD_READ, 16'h7fff);
        settle();
        program_frame('0, '0);
        repeat (2) send(CMD_READ, 16'h0000);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            idle_on   = (phase % 3 != 2);
            len       = ($urandom_range(0, 7) == 0) ? '0 : FLEN_W'($urandom_range(1, 10));
            thr       = ($urandom_range(0, 5) == 0) ? '0 : THR_W'($urandom_range(1, 24));
            program_frame({1'($urandom), len}, thr);
            store_pct = $urandom_range(35, 65);
            if (phase == 3) hold_cycles = PRESSURE_HOLD;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < store_pct) begin
                    send(CMD_STORE, pick_sample());
                end else begin
                    send(CMD_READ, pick_sample());
                end
            end
        end

        // longer frame played from stored data, unused top bit set in the length word
        idle_on = 1'b1;
        while (tracker.frame_left != '0) send(CMD_READ, pick_sample());
        settle();
        program_frame({1'b1, FLEN_W'(LONG_FRAME)}, '0);
        while (tracker.stored() < FILL_W'(LONG_FRAME + 4)) send(CMD_STORE, pick_sample());
        repeat (LONG_FRAME) send(CMD_READ, pick_sample());

        // drain into an underrun, then prebuffer back up to the threshold and restart
        settle();
        program_frame(CFG_DATA_W'(RESTART_FRAME), CFG_DATA_W'(RESTART_THRESHOLD));
        while (tracker.primed || tracker.frame_left != '0) send(CMD_READ, pick_sample());
        while (tracker.stored() < FILL_W'(RESTART_THRESHOLD - 1)) begin
            send(CMD_STORE, pick_sample());
        end
        repeat (RESTART_FRAME) send(CMD_READ, pick_sample());
        send(CMD_STORE, pick_sample());
        repeat (RESTART_THRESHOLD + RESTART_FRAME) send(CMD_READ, pick_sample());

        // one-sample frames: play out what is left, then every read underruns
        settle();
        idle_on = 1'b0;
        program_frame(CFG_DATA_W'(1), '0);
        repeat (3) send(CMD_STORE, pick_sample());
        while (tracker.stored() != '0) send(CMD_READ, pick_sample());
        repeat (5) send(CMD_READ, pick_sample());
        settle();

        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
